@@ src/isad_pkg.sv @@
`timescale 1ns / 1ps

package isad_pkg;

	// table geometry
	localparam int NUM_REGIONS_DEF = 4;
	localparam int BITS_PER_REGION = 8;
	localparam int BIT_W           = 3;
	localparam int QUEUE_DEPTH     = 2;

	// region code check and card programming word
	localparam logic [7:0] REGION_BASE = 8'h40;
	localparam logic [7:0] REGION_SEL  = 8'h06;
	localparam logic [5:0] PROG_ENABLE = 6'h20;

	// request modes
	localparam logic [1:0] MODE_ATTACH  = 2'd0;
	localparam logic [1:0] MODE_DETACH  = 2'd1;
	localparam logic [1:0] MODE_SERVICE = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD      = 3'd1;
	localparam logic [2:0] ST_DUP      = 3'd2;
	localparam logic [2:0] ST_NOSPACE  = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;
	localparam logic [2:0] ST_PULSE    = 3'd5;
	localparam logic [2:0] ST_NONE     = 3'd6;

	// operation decided by the front end
	typedef enum logic [1:0] {
		OP_REJECT  = 2'd0,
		OP_ATTACH  = 2'd1,
		OP_DETACH  = 2'd2,
		OP_SERVICE = 2'd3
	} op_t;

	typedef struct packed {
		logic        [1:0]  mode;
		logic        [11:0] card_address;
		logic        [7:0]  region_code;
		logic signed [15:0] source_code;
		logic signed [31:0] source_value;
		logic        [1:0]  region_index;
		logic        [7:0]  status_bits;
	} req_t;

	typedef struct packed {
		logic        [2:0]  status;
		logic        [5:0]  program_word;
		logic        [11:0] card_echo;
		logic        [1:0]  assigned_region;
		logic        [2:0]  assigned_bit;
		logic signed [15:0] pulse_code_out;
		logic signed [31:0] pulse_value_out;
		logic               last;
	} rsp_t;

	typedef struct packed {
		op_t  op;
		req_t item;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} qstat_t;

endpackage

@@ src/isad_chan_if.sv @@
`timescale 1ns / 1ps

interface isad_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/isad_front.sv @@
`timescale 1ns / 1ps

module isad_front #(
	parameter int NUM_REGIONS = isad_pkg::NUM_REGIONS_DEF
) (
	isad_chan_if.sink           req,
	input  logic                full,
	output logic                push,
	output isad_pkg::cmd_t      cmd
);

	// take a request whenever the queue has room
	assign req.ready = !full;
	assign push      = req.valid && !full;

	// classify the request, catching bad codes up front
	always_comb begin
		cmd.item = req.data;
		cmd.op   = isad_pkg::OP_REJECT;
		case (req.data.mode)
			isad_pkg::MODE_ATTACH: begin
				if (((req.data.region_code & ~isad_pkg::REGION_SEL) == isad_pkg::REGION_BASE) &&
					(req.data.card_address != 12'd0))
					cmd.op = isad_pkg::OP_ATTACH;
			end
			isad_pkg::MODE_DETACH: begin
				cmd.op = isad_pkg::OP_DETACH;
			end
			isad_pkg::MODE_SERVICE: begin
				if ({30'd0, req.data.region_index} < 32'(NUM_REGIONS))
					cmd.op = isad_pkg::OP_SERVICE;
			end
			default: begin
				cmd.op = isad_pkg::OP_REJECT;
			end
		endcase
	end

endmodule

@@ src/isad_queue.sv @@
`timescale 1ns / 1ps

module isad_queue #(
	parameter int DEPTH = isad_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  isad_pkg::cmd_t   cmd_in,
	input  logic             pop,
	output isad_pkg::cmd_t   cmd_out,
	output isad_pkg::qstat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	isad_pkg::cmd_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign cmd_out       = entry_q[rd_ptr_q];
	assign stat.full     = (cnt_q == CNT_W'(DEPTH));
	assign stat.nonempty = (cnt_q != '0);

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= cmd_in;
	end

endmodule

@@ src/isad_back.sv @@
`timescale 1ns / 1ps

module isad_back #(
	parameter int NUM_REGIONS = isad_pkg::NUM_REGIONS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  isad_pkg::cmd_t cmd,
	input  logic           cmd_valid,
	output logic           pop,
	isad_chan_if.source    rsp
);

	localparam int BPR    = isad_pkg::BITS_PER_REGION;
	localparam int BIT_W  = isad_pkg::BIT_W;
	localparam int REG_W  = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
	localparam int SLOT_W = REG_W + BIT_W;
	localparam int NSLOTS = NUM_REGIONS * BPR;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NSLOTS - 1);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SCAN   = 6'b000010,
		S_REGION = 6'b000100,
		S_ALLOC  = 6'b001000,
		S_SVC    = 6'b010000,
		S_EMIT   = 6'b100000
	} state_t;

	state_t               state_q;
	isad_pkg::cmd_t       cmd_q;
	logic [7:0]           region_addr_q [NUM_REGIONS];
	logic [BPR-1:0]       in_use_q [NUM_REGIONS];
	logic [SLOT_W-1:0]    scan_q;
	logic                 scan_done_q;
	logic                 chk_v_s1;
	logic [SLOT_W-1:0]    slot_s1;
	logic [REG_W-1:0]     sel_q;
	logic [BPR-1:0]       pm_q;
	logic                 sv_v_s1;
	logic [BIT_W-1:0]     sv_bit_s1;
	logic                 sv_last_s1;
	isad_pkg::rsp_t       res_q;
	isad_pkg::rsp_t       res_d;
	isad_pkg::rsp_t       pulse_d;
	logic                 out_v_q;
	isad_pkg::rsp_t       out_q;

	// slot memories
	logic        [11:0]   mem_card [NSLOTS];
	logic signed [15:0]   mem_code [NSLOTS];
	logic signed [31:0]   mem_val  [NSLOTS];
	logic        [11:0]   rd_card_s1;
	logic signed [15:0]   rd_code_s1;
	logic signed [31:0]   rd_val_s1;

	logic                 out_free;
	logic [REG_W-1:0]     idle_idx;
	logic [BPR-1:0]       idle_mask;
	logic [REG_W-1:0]     svc_idx;
	logic                 issue;
	logic                 chk_hit;
	logic                 chk_end_miss;
	logic                 rfound;
	logic [REG_W-1:0]     ridx;
	logic                 ffound;
	logic [BIT_W-1:0]     fbit;
	logic [BIT_W-1:0]     plow;
	logic                 load_s1;
	logic                 sv_emit;
	logic                 emit_any;
	logic                 rd_en;
	logic [SLOT_W-1:0]    rd_addr;
	logic                 mem_we;
	logic                 is_detach;

	assign out_free  = !out_v_q || rsp.ready;
	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;
	assign pop       = (state_q == S_IDLE) && cmd_valid;
	assign is_detach = (cmd_q.op == isad_pkg::OP_DETACH);

	assign idle_idx  = REG_W'(cmd.item.region_index);
	assign idle_mask = cmd.item.status_bits & in_use_q[idle_idx];
	assign svc_idx   = REG_W'(cmd_q.item.region_index);

	// card address scan, one slot per cycle, compare in the cycle after the read
	assign issue        = (state_q == S_SCAN) && !scan_done_q;
	assign chk_hit      = chk_v_s1 && in_use_q[slot_s1[SLOT_W-1:BIT_W]][slot_s1[BIT_W-1:0]] &&
	                      (rd_card_s1 == cmd_q.item.card_address);
	assign chk_end_miss = chk_v_s1 && !chk_hit && (slot_s1 == LAST_SLOT);

	// first region entry that matches the code or is still unused
	always_comb begin
		rfound = 1'b0;
		ridx   = '0;
		for (int i = NUM_REGIONS - 1; i >= 0; i--) begin
			if ((region_addr_q[i] == 8'd0) || (region_addr_q[i] == cmd_q.item.region_code)) begin
				rfound = 1'b1;
				ridx   = REG_W'(i);
			end
		end
	end

	// lowest free bit of the chosen region
	always_comb begin
		ffound = 1'b0;
		fbit   = '0;
		for (int b = BPR - 1; b >= 0; b--) begin
			if (!in_use_q[sel_q][b]) begin
				ffound = 1'b1;
				fbit   = BIT_W'(b);
			end
		end
	end

	// lowest pending source bit
	always_comb begin
		plow = '0;
		for (int b = BPR - 1; b >= 0; b--) begin
			if (pm_q[b])
				plow = BIT_W'(b);
		end
	end

	// pulse pipeline: read slot, then hand to the output register
	assign load_s1  = (state_q == S_SVC) && (pm_q != '0) && (!sv_v_s1 || out_free);
	assign sv_emit  = (state_q == S_SVC) && sv_v_s1 && out_free;
	assign emit_any = ((state_q == S_EMIT) && out_free) || sv_emit;

	assign rd_en   = issue || load_s1;
	assign rd_addr = issue ? scan_q : {svc_idx, plow};
	assign mem_we  = (state_q == S_ALLOC) && ffound;

	// single result for the current state
	always_comb begin
		res_d      = '0;
		res_d.last = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (cmd.op == isad_pkg::OP_SERVICE) begin
					res_d.status          = isad_pkg::ST_NONE;
					res_d.assigned_region = cmd.item.region_index;
				end else begin
					res_d.status = isad_pkg::ST_BAD;
				end
			end
			S_SCAN: begin
				if (chk_hit && is_detach) begin
					res_d.status          = isad_pkg::ST_OK;
					res_d.card_echo       = cmd_q.item.card_address;
					res_d.assigned_region = 2'(slot_s1[SLOT_W-1:BIT_W]);
					res_d.assigned_bit    = slot_s1[BIT_W-1:0];
				end else if (chk_hit) begin
					res_d.status = isad_pkg::ST_DUP;
				end else begin
					res_d.status = isad_pkg::ST_NOTFOUND;
				end
			end
			S_ALLOC: begin
				if (ffound) begin
					res_d.status          = isad_pkg::ST_OK;
					res_d.program_word    = isad_pkg::PROG_ENABLE |
						6'((cmd_q.item.region_code & isad_pkg::REGION_SEL) << 2) | 6'(fbit);
					res_d.card_echo       = cmd_q.item.card_address;
					res_d.assigned_region = 2'(sel_q);
					res_d.assigned_bit    = fbit;
				end else begin
					res_d.status = isad_pkg::ST_NOSPACE;
				end
			end
			default: begin
				res_d.status = isad_pkg::ST_NOSPACE;
			end
		endcase
	end

	// pulse result from the slot read
	always_comb begin
		pulse_d                 = '0;
		pulse_d.status          = isad_pkg::ST_PULSE;
		pulse_d.card_echo       = rd_card_s1;
		pulse_d.assigned_region = 2'(svc_idx);
		pulse_d.assigned_bit    = sv_bit_s1;
		pulse_d.pulse_code_out  = rd_code_s1;
		pulse_d.pulse_value_out = rd_val_s1;
		pulse_d.last            = sv_last_s1;
	end

	// control state and region table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			region_addr_q <= '{default: '0};
			in_use_q      <= '{default: '0};
			scan_q        <= '0;
			scan_done_q   <= 1'b0;
			chk_v_s1      <= 1'b0;
			sel_q         <= '0;
			pm_q          <= '0;
			sv_v_s1       <= 1'b0;
			out_v_q       <= 1'b0;
		end else begin
			chk_v_s1 <= issue && !(chk_hit || chk_end_miss);
			if (issue) begin
				scan_q <= scan_q + 1'b1;
				if (scan_q == LAST_SLOT)
					scan_done_q <= 1'b1;
			end
			if (load_s1) begin
				sv_v_s1 <= 1'b1;
				pm_q    <= pm_q & ~(BPR'(1) << plow);
			end else if (sv_emit) begin
				sv_v_s1 <= 1'b0;
			end
			if (emit_any)
				out_v_q <= 1'b1;
			else if (rsp.ready)
				out_v_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						case (cmd.op)
							isad_pkg::OP_ATTACH, isad_pkg::OP_DETACH: begin
								scan_q      <= '0;
								scan_done_q <= 1'b0;
								state_q     <= S_SCAN;
							end
							isad_pkg::OP_SERVICE: begin
								if (idle_mask == '0) begin
									state_q <= S_EMIT;
								end else begin
									pm_q    <= idle_mask;
									state_q <= S_SVC;
								end
							end
							default: begin
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (chk_hit) begin
						if (is_detach)
							in_use_q[slot_s1[SLOT_W-1:BIT_W]][slot_s1[BIT_W-1:0]] <= 1'b0;
						state_q <= S_EMIT;
					end else if (chk_end_miss) begin
						state_q <= is_detach ? S_EMIT : S_REGION;
					end
				end
				S_REGION: begin
					if (rfound) begin
						region_addr_q[ridx] <= cmd_q.item.region_code;
						sel_q               <= ridx;
						state_q             <= S_ALLOC;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_ALLOC: begin
					if (ffound)
						in_use_q[sel_q][fbit] <= 1'b1;
					state_q <= S_EMIT;
				end
				S_SVC: begin
					if (sv_emit && sv_last_s1)
						state_q <= S_IDLE;
				end
				S_EMIT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop)
			cmd_q <= cmd;
		if (issue)
			slot_s1 <= scan_q;
		if (load_s1) begin
			sv_bit_s1  <= plow;
			sv_last_s1 <= ((pm_q & ~(BPR'(1) << plow)) == '0);
		end
		if (state_q != S_EMIT)
			res_q <= res_d;
		if (emit_any)
			out_q <= (state_q == S_EMIT) ? res_q : pulse_d;
	end

	// slot memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_card[{sel_q, fbit}] <= cmd_q.item.card_address;
			mem_code[{sel_q, fbit}] <= cmd_q.item.source_code;
			mem_val[{sel_q, fbit}]  <= cmd_q.item.source_value;
		end
		if (rd_en) begin
			rd_card_s1 <= mem_card[rd_addr];
			rd_code_s1 <= mem_code[rd_addr];
			rd_val_s1  <= mem_val[rd_addr];
		end
	end

endmodule

@@ src/interrupt_slot_allocator_dispatcher_core.sv @@
// Attach and detach requests wait on the one-slot-a-cycle card scan, which stops on a matching
// card; attach then picks a region and a free bit. Reject and service requests need no scan.
// Service emits one pulse per cycle after the first while rsp.ready stays high; requests run one
// at a time in the back end, while a two-entry queue keeps taking requests behind it.
// Asynchronous active-low reset clears the region table, the bits in use and all handshake state;
// slot contents are undefined until a card is attached there.
`timescale 1ns / 1ps

module interrupt_slot_allocator_dispatcher_core #(
	parameter int NUM_REGIONS = isad_pkg::NUM_REGIONS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	isad_chan_if.sink   req,
	isad_chan_if.source rsp
);

	logic             push;
	logic             pop;
	isad_pkg::cmd_t   cmd_in;
	isad_pkg::cmd_t   cmd_out;
	isad_pkg::qstat_t qstat;

	// request decode
	isad_front #(
		.NUM_REGIONS(NUM_REGIONS)
	) u_front (
		.req  (req),
		.full (qstat.full),
		.push (push),
		.cmd  (cmd_in)
	);

	// command queue between decode and execution
	isad_queue #(
		.DEPTH(isad_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.cmd_in  (cmd_in),
		.pop     (pop),
		.cmd_out (cmd_out),
		.stat    (qstat)
	);

	// table update and dispatch
	isad_back #(
		.NUM_REGIONS(NUM_REGIONS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_valid (qstat.nonempty),
		.pop       (pop),
		.rsp       (rsp)
	);

`ifndef ASSERT_OFF
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qstat.nonempty)
		else $error("back end popped an empty queue");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.data.status != isad_pkg::ST_PULSE)) |-> rsp.data.last)
		else $error("non-pulse result not marked last");

	a_prog_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.data.status == isad_pkg::ST_OK) && (rsp.data.program_word != 6'd0))
		|-> (rsp.data.program_word[2:0] == rsp.data.assigned_bit))
		else $error("programming word disagrees with assigned bit");
`endif

endmodule
